// ===== hw/rtl/xs64_pkg.sv =====
// ----------------------------------------------------------------------------
// xs64_pkg
// Shared types, constants and the xorshift step for the ranged random block.
// ----------------------------------------------------------------------------
`default_nettype none

package xs64_pkg;

    localparam int RAW_W  = 64;   // generator state and raw number
    localparam int SPAN_W = 33;   // span of an integer range reaches 2^32
    localparam int VAL_W  = 32;
    localparam int PCT_W  = 7;
    localparam int CNT_W  = $clog2(RAW_W);

    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 7;
    localparam int SHIFT_C = 17;

    localparam logic [RAW_W-1:0]  SEED_RESET   = RAW_W'(1);
    localparam logic [SPAN_W-1:0] COIN_SPAN    = SPAN_W'(2);
    localparam logic [SPAN_W-1:0] PERCENT_SPAN = SPAN_W'(100);

    typedef enum logic [1:0] {
        CMD_RANGE = 2'd0,
        CMD_ENUM  = 2'd1,
        CMD_COIN  = 2'd2,
        CMD_FLAG  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_OUT
    } t_state;

    function automatic logic [RAW_W-1:0] xs64_next(input logic [RAW_W-1:0] s);
        logic [RAW_W-1:0] x;
        x = s;
        x = x ^ (x << SHIFT_A);
        x = x ^ (x >> SHIFT_B);
        x = x ^ (x << SHIFT_C);
        return x;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/xorshift64_ranged_random.sv =====
// ----------------------------------------------------------------------------
// xorshift64_ranged_random
// Ranged random numbers from a 64-bit xorshift generator (shifts 13, 7, 17).
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel: one beat writes the seed; the state reloads with it, a zero
//   seed loads 1. Taken only while the block is idle, ahead of a request.
//   in channel: one beat is one request (cmd selects integer range, enum
//   index, coin flip or percent flag). out channel: one value beat per request.
// Flow:
//   a request that draws a number passes through the bit-serial remainder
//   unit, which shifts in all 64 dividend bits, one per step, and then
//   through the control states. A new request is taken once the previous
//   one has reached the output register, so the block works on one request
//   at a time. A degenerate request (low bound not below high bound, count
//   of at most one) skips the generator and goes straight to the output.
// Reset: state loads 1, output register empties.
// Stall: a result waits in the output register while the next request is
//   taken and worked on; that request's result waits for the register to free.
// ----------------------------------------------------------------------------
`default_nettype none

module xorshift64_ranged_random
    import xs64_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [RAW_W-1:0]    i_cfg_seed,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [1:0]          i_cmd,
    input  wire logic signed [31:0]  i_low_bound,
    input  wire logic signed [31:0]  i_high_bound,
    input  wire logic [30:0]         i_item_count,
    input  wire logic [PCT_W-1:0]    i_percent,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic signed [31:0]       o_value
);

    t_state             r_fsm,   n_fsm;
    logic [RAW_W-1:0]   r_gen,   n_gen;
    t_cmd               r_cmd,   n_cmd;
    logic [VAL_W-1:0]   r_low,   n_low;
    logic [PCT_W-1:0]   r_pct,   n_pct;
    logic [VAL_W-1:0]   r_res,   n_res;
    logic               r_ovld,  n_ovld;
    logic [VAL_W-1:0]   r_oval,  n_oval;

    logic               mod_start;
    logic               mod_done;
    logic [SPAN_W-1:0]  mod_rem;
    logic [SPAN_W-1:0]  span;
    logic [SPAN_W-1:0]  span_rng;
    logic               degen;
    logic [VAL_W-1:0]   degen_val;
    logic [RAW_W-1:0]   raw;
    t_cmd               in_cmd;

    assign in_cmd = t_cmd'(i_cmd);
    assign raw    = xs64_next(r_gen);

    // high - low + 1 at 33 bits, at most 2^32 when low < high
    assign span_rng = SPAN_W'($unsigned({i_high_bound[31], i_high_bound}
                                        - {i_low_bound[31], i_low_bound}))
                      + SPAN_W'(1);

    always_comb begin
        degen     = 1'b0;
        degen_val = '0;
        span      = COIN_SPAN;
        unique case (in_cmd)
            CMD_RANGE: begin
                degen     = i_low_bound >= i_high_bound;
                degen_val = i_low_bound;
                span      = span_rng;
            end
            CMD_ENUM: begin
                degen = i_item_count <= 31'd1;
                span  = SPAN_W'(i_item_count);
            end
            CMD_COIN: begin
                span = COIN_SPAN;
            end
            CMD_FLAG: begin
                span = PERCENT_SPAN;
            end
            default: begin
                span = COIN_SPAN;
            end
        endcase
    end

    xs64_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (raw),
        .i_divisor  (span),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign o_cfg_ready = r_fsm == S_IDLE;
    assign o_in_ready  = r_fsm == S_IDLE && !i_cfg_valid;

    always_comb begin
        n_fsm     = r_fsm;
        n_gen     = r_gen;
        n_cmd     = r_cmd;
        n_low     = r_low;
        n_pct     = r_pct;
        n_res     = r_res;
        n_ovld    = r_ovld;
        n_oval    = r_oval;
        mod_start = 1'b0;

        if (r_ovld && i_out_ready) begin
            n_ovld = 1'b0;
        end

        unique case (r_fsm)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    n_gen = (i_cfg_seed == '0) ? SEED_RESET : i_cfg_seed;
                end else if (i_in_valid) begin
                    n_cmd = in_cmd;
                    n_low = i_low_bound;
                    n_pct = i_percent;
                    if (degen) begin
                        n_res = degen_val;
                        n_fsm = S_OUT;
                    end else begin
                        n_gen     = raw;
                        mod_start = 1'b1;
                        n_fsm     = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (mod_done) begin
                    case (r_cmd) inside
                        CMD_RANGE: n_res = r_low + mod_rem[VAL_W-1:0];
                        CMD_FLAG: begin
                            // 1 + rem <= percent
                            n_res = VAL_W'(mod_rem < SPAN_W'(r_pct));
                        end
                        CMD_ENUM, CMD_COIN: n_res = mod_rem[VAL_W-1:0];
                        default: n_res = mod_rem[VAL_W-1:0];
                    endcase
                    n_fsm = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovld || i_out_ready) begin
                    n_ovld = 1'b1;
                    n_oval = r_res;
                    n_fsm  = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= S_IDLE;
        end else begin
            r_fsm <= n_fsm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen  <= SEED_RESET;
            r_ovld <= 1'b0;
        end else begin
            r_gen  <= n_gen;
            r_ovld <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_low  <= n_low;
        r_pct  <= n_pct;
        r_res  <= n_res;
        r_oval <= n_oval;
    end

    assign o_out_valid = r_ovld;
    assign o_value     = r_oval;

endmodule

`default_nettype wire

// ===== hw/rtl/xs64_mod.sv =====
// ----------------------------------------------------------------------------
// xs64_mod
// Bit-serial restoring remainder: 64-bit dividend modulo a 33-bit divisor,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module xs64_mod
    import xs64_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [RAW_W-1:0]  i_dividend,
    input  wire logic [SPAN_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [SPAN_W-1:0]      o_rem
);

    logic [RAW_W-1:0]  r_dvd;
    logic [SPAN_W-1:0] r_dvs;
    logic [SPAN_W-1:0] r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [SPAN_W:0]   trial;
    logic              fits;
    logic [SPAN_W-1:0] n_rem;

    // remainder stays below the divisor, so the shifted trial fits one extra bit
    assign trial = {r_rem, r_dvd[RAW_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};
    assign n_rem = fits ? SPAN_W'(trial - {1'b0, r_dvs}) : trial[SPAN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_cnt <= CNT_W'(RAW_W - 1);
        end else if (r_busy) begin
            r_dvd <= {r_dvd[RAW_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire
